[design/bscb_pkg.sv]
// Shared types and constants for the B-spline cell to Bezier point converter.
`timescale 1ns / 1ps
`default_nettype none

package bscb_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned HGT_W         = 32;
  localparam int unsigned POS_W         = 2;
  localparam int unsigned LANES         = 3;
  localparam int unsigned NPTS          = 3;

  // position codes; the unused code behaves as a middle position
  localparam logic [POS_W-1:0] POS_FIRST  = 2'd0;
  localparam logic [POS_W-1:0] POS_MIDDLE = 2'd1;
  localparam logic [POS_W-1:0] POS_LAST   = 2'd2;

  typedef logic signed [HGT_W-1:0] hgt_t;

  // pass control: pos steers this pass, aux rides along for the next one
  typedef struct packed {
    logic             valid;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] aux;
  } ctl_t;

  // nine result heights, entry r*3+c is sub-row r, sub-column c
  typedef logic [LANES*NPTS-1:0][HGT_W-1:0] bez_t;

endpackage

`default_nettype wire

[design/bscb_if.sv]
// Channel interfaces: cell neighborhood in, Bezier heights out.
`timescale 1ns / 1ps
`default_nettype none

interface bscb_cell_if import bscb_pkg::*; ();
  logic             valid;
  logic             ready;
  hgt_t             z_up_left;
  hgt_t             z_up;
  hgt_t             z_up_right;
  hgt_t             z_left;
  hgt_t             z_center;
  hgt_t             z_right;
  hgt_t             z_down_left;
  hgt_t             z_down;
  hgt_t             z_down_right;
  logic [POS_W-1:0] row_pos;
  logic [POS_W-1:0] col_pos;

  modport source (
    output valid, z_up_left, z_up, z_up_right, z_left, z_center, z_right,
           z_down_left, z_down, z_down_right, row_pos, col_pos,
    input  ready
  );
  modport sink (
    input  valid, z_up_left, z_up, z_up_right, z_left, z_center, z_right,
           z_down_left, z_down, z_down_right, row_pos, col_pos,
    output ready
  );
endinterface

interface bscb_bez_if import bscb_pkg::*; ();
  logic valid;
  logic ready;
  hgt_t bez_r0_c0;
  hgt_t bez_r0_c1;
  hgt_t bez_r0_c2;
  hgt_t bez_r1_c0;
  hgt_t bez_r1_c1;
  hgt_t bez_r1_c2;
  hgt_t bez_r2_c0;
  hgt_t bez_r2_c1;
  hgt_t bez_r2_c2;

  modport source (
    output valid, bez_r0_c0, bez_r0_c1, bez_r0_c2, bez_r1_c0, bez_r1_c1,
           bez_r1_c2, bez_r2_c0, bez_r2_c1, bez_r2_c2,
    input  ready
  );
  modport sink (
    input  valid, bez_r0_c0, bez_r0_c1, bez_r0_c2, bez_r1_c0, bez_r1_c1,
           bez_r1_c2, bez_r2_c0, bez_r2_c1, bez_r2_c2,
    output ready
  );
endinterface

`default_nettype wire

[design/bscb_pass.sv]
// Four-stage three-point pass over three lanes (difference, multiply, add, average/select).
`timescale 1ns / 1ps
`default_nettype none

module bscb_pass import bscb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  ctl_t ctl_i,
  input  hgt_t trip_i [LANES][3],
  output ctl_t ctl_o,
  output hgt_t pts_o [LANES][NPTS]
);

  localparam int unsigned TW = FRAC_BITS + 2;
  localparam int unsigned DW = HGT_W + 1;
  localparam int unsigned PW = DW + TW;
  localparam logic signed [TW-1:0] T1 = TW'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
  localparam logic signed [TW-1:0] T2 = TW'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);

  ctl_t c1_q, c2_q, c3_q, c4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (en_i) begin
      c1_q <= ctl_i;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  assign ctl_o = c4_q;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [DW-1:0] dcn_d, dpc_d, dcn_q, dpc_q;
    logic signed [PW-1:0] prod1, prod2, prodp;
    logic signed [DW-1:0] diff, half;
    hgt_t prev1_q, cur1_q;
    hgt_t prev2_q, cur2_q, m1_q, m2_q, mp_q;
    hgt_t cur3_q, p1_q, p2_q, q_q;
    hgt_t p0;
    hgt_t pts_d [NPTS];
    hgt_t pts_q [NPTS];

    // stage 1: differences in 33 bits
    always_comb begin
      dcn_d = DW'(trip_i[l][2]) - DW'(trip_i[l][1]);
      dpc_d = DW'(trip_i[l][1]) - DW'(trip_i[l][0]);
    end

    // stage 2: scale by 1/3 and 2/3, floor through arithmetic shift
    assign prod1 = dcn_q * T1;
    assign prod2 = dcn_q * T2;
    assign prodp = dpc_q * T2;

    // stage 4: midpoint of the left 2/3 point and the right 1/3 point; pos selects the outputs
    always_comb begin
      diff = DW'(p1_q) - DW'(q_q);
      half = diff >>> 1;
      p0   = q_q + half[HGT_W-1:0];
      unique case (c3_q.pos)
        POS_FIRST: begin
          pts_d[0] = cur3_q;
          pts_d[1] = p1_q;
          pts_d[2] = p2_q;
        end
        POS_LAST: begin
          pts_d[0] = cur3_q;
          pts_d[1] = '0;
          pts_d[2] = '0;
        end
        default: begin
          pts_d[0] = p0;
          pts_d[1] = p1_q;
          pts_d[2] = p2_q;
        end
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        prev1_q <= trip_i[l][0];
        cur1_q  <= trip_i[l][1];
        dcn_q   <= dcn_d;
        dpc_q   <= dpc_d;
        prev2_q <= prev1_q;
        cur2_q  <= cur1_q;
        m1_q    <= prod1[FRAC_BITS +: HGT_W];
        m2_q    <= prod2[FRAC_BITS +: HGT_W];
        mp_q    <= prodp[FRAC_BITS +: HGT_W];
        cur3_q  <= cur2_q;
        p1_q    <= cur2_q + m1_q;
        p2_q    <= cur2_q + m2_q;
        q_q     <= prev2_q + mp_q;
        pts_q   <= pts_d;
      end
    end

    assign pts_o[l] = pts_q;
  end

endmodule

`default_nettype wire

[design/bscb_skid.sv]
// Output register with one skid entry; upstream ready comes from a flop.
`timescale 1ns / 1ps
`default_nettype none

module bscb_skid import bscb_pkg::*; #(
  parameter int unsigned DW = $bits(bez_t)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  logic [DW-1:0] data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [DW-1:0] data_o
);

  logic          out_valid_q, skid_valid_q;
  logic [DW-1:0] out_q, skid_q;

  assign ready_o = ~skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (ready_i || !out_valid_q) begin
      // drain the skid entry first; no new beat is taken while it is full
      out_valid_q  <= skid_valid_q | valid_i;
      skid_valid_q <= 1'b0;
    end else if (valid_i && !skid_valid_q) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_i || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : data_i;
    end else if (valid_i && !skid_valid_q) begin
      skid_q <= data_i;
    end
  end

endmodule

`default_nettype wire

[design/bspline_cell_to_bezier_points.sv]
// Top level: uniform cubic B-spline 3x3 cell neighborhood to 3x3 Bezier heights.
//
//   channel  dir  handshake      payload
//   cell_i   in   valid/ready    z_up_left .. z_down_right, row_pos, col_pos
//   bez_o    out  valid/ready    bez_r0_c0 .. bez_r2_c2
//
// One cell per clock unless bez_o stalls. A cell passes through a four-stage
// horizontal pass, a four-stage vertical pass (difference, multiply, add,
// average) and the output register.
// Reset clears only valid, pos and aux bits; data registers keep their values.
// A stall on bez_o fills the skid entry and drops cell_i.ready the next cycle;
// the whole pipeline then holds until the skid entry drains.
`timescale 1ns / 1ps
`default_nettype none

module bspline_cell_to_bezier_points import bscb_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  bscb_cell_if.sink         cell_i,
  bscb_bez_if.source        bez_o
);

  logic pipe_en;
  ctl_t h_ctl_in, h_ctl, v_ctl_in, v_ctl;
  hgt_t h_trip [LANES][3];
  hgt_t h_pts  [LANES][NPTS];
  hgt_t v_trip [LANES][3];
  hgt_t v_pts  [LANES][NPTS];
  bez_t bez_d, bez_q;

  assign cell_i.ready = pipe_en;

  always_comb begin
    h_ctl_in.valid = cell_i.valid;
    h_ctl_in.pos   = cell_i.col_pos;
    h_ctl_in.aux   = cell_i.row_pos;
    h_trip[0][0] = cell_i.z_up_left;
    h_trip[0][1] = cell_i.z_up;
    h_trip[0][2] = cell_i.z_up_right;
    h_trip[1][0] = cell_i.z_left;
    h_trip[1][1] = cell_i.z_center;
    h_trip[1][2] = cell_i.z_right;
    h_trip[2][0] = cell_i.z_down_left;
    h_trip[2][1] = cell_i.z_down;
    h_trip[2][2] = cell_i.z_down_right;
  end

  bscb_pass #(.FRAC_BITS(FRAC_BITS)) u_hpass (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctl_i  (h_ctl_in),
    .trip_i (h_trip),
    .ctl_o  (h_ctl),
    .pts_o  (h_pts)
  );

  // transpose: each vertical lane walks one horizontal column down the rows
  always_comb begin
    v_ctl_in.valid = h_ctl.valid;
    v_ctl_in.pos   = h_ctl.aux;
    v_ctl_in.aux   = h_ctl.pos;
    for (int c = 0; c < LANES; c++) begin
      for (int k = 0; k < 3; k++) begin
        v_trip[c][k] = h_pts[k][c];
      end
    end
  end

  bscb_pass #(.FRAC_BITS(FRAC_BITS)) u_vpass (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (pipe_en),
    .ctl_i  (v_ctl_in),
    .trip_i (v_trip),
    .ctl_o  (v_ctl),
    .pts_o  (v_pts)
  );

  always_comb begin
    for (int r = 0; r < NPTS; r++) begin
      for (int c = 0; c < LANES; c++) begin
        bez_d[r*LANES+c] = v_pts[c][r];
      end
    end
  end

  bscb_skid #(.DW($bits(bez_t))) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v_ctl.valid),
    .ready_o (pipe_en),
    .data_i  (bez_d),
    .valid_o (bez_o.valid),
    .ready_i (bez_o.ready),
    .data_o  (bez_q)
  );

  assign bez_o.bez_r0_c0 = bez_q[0];
  assign bez_o.bez_r0_c1 = bez_q[1];
  assign bez_o.bez_r0_c2 = bez_q[2];
  assign bez_o.bez_r1_c0 = bez_q[3];
  assign bez_o.bez_r1_c1 = bez_q[4];
  assign bez_o.bez_r1_c2 = bez_q[5];
  assign bez_o.bez_r2_c0 = bez_q[6];
  assign bez_o.bez_r2_c1 = bez_q[7];
  assign bez_o.bez_r2_c2 = bez_q[8];

  // a full skid entry always sits behind a valid output beat
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |-> bez_o.valid)
    else $error("skid entry full while output register empty");

  // the pipeline holds while the skid entry is full
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(v_ctl))
    else $error("pipeline advanced during stall");

  // last column: sub-columns 1 and 2 come out zero
  a_last_col_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_ctl.valid && v_ctl.aux == POS_LAST) |->
      (v_pts[1][0] == '0 && v_pts[1][1] == '0 && v_pts[1][2] == '0 &&
       v_pts[2][0] == '0 && v_pts[2][1] == '0 && v_pts[2][2] == '0))
    else $error("last column produced nonzero sub-columns");

  // last row: sub-rows 1 and 2 come out zero
  a_last_row_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_ctl.valid && v_ctl.pos == POS_LAST) |->
      (v_pts[0][1] == '0 && v_pts[0][2] == '0 && v_pts[1][1] == '0 &&
       v_pts[1][2] == '0 && v_pts[2][1] == '0 && v_pts[2][2] == '0))
    else $error("last row produced nonzero sub-rows");

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the B-spline cell to Bezier height converter.
`timescale 1ns / 1ps

module testbench;
  import bscb_pkg::*;

  localparam longint T_THIRD     = ((longint'(1) << FRAC_BITS_DEF) + 1) / 3;
  localparam longint T_TWO_THIRD = ((longint'(2) << FRAC_BITS_DEF) + 1) / 3;
  localparam longint T_HALF      = longint'(1) << (FRAC_BITS_DEF - 1);
  localparam int     RANDOM_CELLS = 400;
  localparam int     SWEEP_CELLS  = 350;
  localparam int     DRAIN_CYCLES = 20;

  localparam hgt_t H_MAX = 32'sh7fff_ffff;
  localparam hgt_t H_MIN = 32'sh8000_0000;

  // z[0..8]: up_left, up, up_right, left, center, right, down_left, down, down_right
  typedef struct packed {
    logic [8:0][HGT_W-1:0] z;
    logic [POS_W-1:0]      row_pos;
    logic [POS_W-1:0]      col_pos;
  } cell_t;

  logic clk_i;
  logic rst_ni;

  bscb_cell_if cell_if ();
  bscb_bez_if  bez_if ();

  bspline_cell_to_bezier_points #(
    .FRAC_BITS(FRAC_BITS_DEF)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cell_i(cell_if),
    .bez_o (bez_if)
  );

  bez_t pending_bez_q [$];
  int   fail_count;
  int   burst_left;
  int   stall_left;
  int   stall_mode;
  int   stall_tick;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------- predictor

  // a + floor((b - a) * t / 2^FRAC_BITS), exact in 64 bits
  function automatic hgt_t blend(hgt_t a, hgt_t b, longint t);
    longint prod;
    prod = (longint'(b) - longint'(a)) * t;
    return hgt_t'(longint'(a) + (prod >>> FRAC_BITS_DEF));
  endfunction

  // split one span of three control heights into three Bezier points
  function automatic void split_span(input hgt_t prv, input hgt_t cur, input hgt_t nxt,
                                     input logic [POS_W-1:0] pos,
                                     output hgt_t p0, output hgt_t p1, output hgt_t p2);
    case (pos)
      POS_FIRST: begin
        p0 = cur;
        p1 = blend(cur, nxt, T_THIRD);
        p2 = blend(cur, nxt, T_TWO_THIRD);
      end
      POS_LAST: begin
        p0 = cur;
        p1 = '0;
        p2 = '0;
      end
      default: begin
        // unused code 3 falls here too, as a middle position
        p1 = blend(cur, nxt, T_THIRD);
        p2 = blend(cur, nxt, T_TWO_THIRD);
        p0 = blend(blend(prv, cur, T_TWO_THIRD), p1, T_HALF);
      end
    endcase
  endfunction

  function automatic bez_t convert_cell(cell_t c);
    hgt_t h [3][3];
    hgt_t v0, v1, v2;
    bez_t res;
    int   ncols;
    res = '0;
    for (int r = 0; r < 3; r++) begin
      split_span(hgt_t'(c.z[r*3]), hgt_t'(c.z[r*3+1]), hgt_t'(c.z[r*3+2]), c.col_pos,
                 h[r][0], h[r][1], h[r][2]);
    end
    ncols = (c.col_pos == POS_LAST) ? 1 : 3;
    for (int k = 0; k < ncols; k++) begin
      split_span(h[0][k], h[1][k], h[2][k], c.row_pos, v0, v1, v2);
      res[k]   = v0;
      res[3+k] = v1;
      res[6+k] = v2;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- checker

  always @(posedge clk_i) begin
    bez_t got;
    bez_t want;
    if (rst_ni && bez_if.valid && bez_if.ready) begin
      got = {bez_if.bez_r2_c2, bez_if.bez_r2_c1, bez_if.bez_r2_c0,
             bez_if.bez_r1_c2, bez_if.bez_r1_c1, bez_if.bez_r1_c0,
             bez_if.bez_r0_c2, bez_if.bez_r0_c1, bez_if.bez_r0_c0};
      if (pending_bez_q.size() == 0) begin
        $error("unexpected Bezier beat, nothing pending");
        fail_count++;
      end else begin
        want = pending_bez_q.pop_front();
        for (int i = 0; i < LANES*NPTS; i++) begin
          if (got[i] !== want[i]) begin
            $error("bez_r%0d_c%0d: expected %0d, got %0d", i / 3, i % 3,
                   $signed(want[i]), $signed(got[i]));
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  // pick a stall pattern every so often: none, random, periodic, long stalls
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(32, 96);
      stall_mode = $urandom_range(0, 3);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0:       bez_if.ready <= 1'b1;
      1:       bez_if.ready <= 1'($urandom_range(0, 1));
      2:       bez_if.ready <= (stall_tick % 4 == 0);
      default: bez_if.ready <= (stall_tick % 32 >= 24);
    endcase
  end

  // ---------------------------------------------------------------- sender

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk_i);
        cell_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  task automatic send_cell(input cell_t c);
    @(negedge clk_i);
    cell_if.valid        <= 1'b1;
    cell_if.z_up_left    <= c.z[0];
    cell_if.z_up         <= c.z[1];
    cell_if.z_up_right   <= c.z[2];
    cell_if.z_left       <= c.z[3];
    cell_if.z_center     <= c.z[4];
    cell_if.z_right      <= c.z[5];
    cell_if.z_down_left  <= c.z[6];
    cell_if.z_down       <= c.z[7];
    cell_if.z_down_right <= c.z[8];
    cell_if.row_pos      <= c.row_pos;
    cell_if.col_pos      <= c.col_pos;
    do @(posedge clk_i); while (!cell_if.ready);
    pending_bez_q.push_back(convert_cell(c));
    pace_sender();
  endtask

  function automatic hgt_t rand_height();
    case ($urandom_range(0, 9))
      0:       return H_MAX;
      1:       return H_MIN;
      2:       return hgt_t'($urandom_range(0, 2)) - 32'sd1;
      3:       return H_MAX - hgt_t'($urandom_range(0, 255));
      4:       return H_MIN + hgt_t'($urandom_range(0, 255));
      5, 6:    return hgt_t'($urandom_range(0, 32'h001f_ffff)) - 32'sh0010_0000;
      default: return hgt_t'($urandom);
    endcase
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return ($urandom_range(0, 7) == 0) ? 2'd3 : POS_W'($urandom_range(0, 2));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_extremes();
    cell_t c;
    c.row_pos = POS_MIDDLE;
    c.col_pos = POS_MIDDLE;
    for (int k = 0; k < 9; k++) c.z[k] = H_MAX;
    send_cell(c);
    for (int k = 0; k < 9; k++) c.z[k] = H_MIN;
    send_cell(c);
    for (int k = 0; k < 9; k++) c.z[k] = (k % 2) ? H_MAX : H_MIN;
    send_cell(c);
    c.row_pos = POS_FIRST;
    c.col_pos = POS_FIRST;
    send_cell(c);
    c.row_pos = POS_MIDDLE;
    c.col_pos = POS_MIDDLE;
    for (int k = 0; k < 9; k++) c.z[k] = (k == 4) ? H_MAX : H_MIN;
    send_cell(c);
    c.col_pos = POS_FIRST;
    for (int k = 0; k < 9; k++) c.z[k] = (k == 4) ? H_MIN : H_MAX;
    send_cell(c);
    c.col_pos = POS_MIDDLE;
    for (int k = 0; k < 9; k++) c.z[k] = -32'sd1;
    send_cell(c);
    c.row_pos = POS_LAST;
    c.col_pos = POS_LAST;
    for (int k = 0; k < 9; k++) c.z[k] = '0;
    send_cell(c);
  endtask

  // every row and column code, the unused code included
  task automatic test_position_codes();
    cell_t c;
    for (int rp = 0; rp < 4; rp++) begin
      for (int cp = 0; cp < 4; cp++) begin
        for (int k = 0; k < 9; k++) c.z[k] = rand_height();
        c.row_pos = POS_W'(rp);
        c.col_pos = POS_W'(cp);
        send_cell(c);
      end
    end
  endtask

  // walk real grids cell by cell; neighbors off the grid are junk
  task automatic test_grid_sweep();
    hgt_t  grid [8][8];
    cell_t c;
    int    nrows, ncols, rr, cc, sent;
    sent = 0;
    while (sent < SWEEP_CELLS) begin
      nrows = $urandom_range(2, 6);
      ncols = $urandom_range(2, 6);
      for (int r = 0; r < nrows; r++)
        for (int k = 0; k < ncols; k++) grid[r][k] = rand_height();
      for (int r = 0; r < nrows; r++) begin
        for (int k = 0; k < ncols; k++) begin
          for (int dr = 0; dr < 3; dr++) begin
            for (int dc = 0; dc < 3; dc++) begin
              rr = r + dr - 1;
              cc = k + dc - 1;
              if (rr >= 0 && rr < nrows && cc >= 0 && cc < ncols)
                c.z[dr*3+dc] = grid[rr][cc];
              else
                c.z[dr*3+dc] = $urandom;
            end
          end
          c.row_pos = (r == 0) ? POS_FIRST : (r == nrows - 1) ? POS_LAST : POS_MIDDLE;
          c.col_pos = (k == 0) ? POS_FIRST : (k == ncols - 1) ? POS_LAST : POS_MIDDLE;
          send_cell(c);
          sent++;
        end
      end
    end
  endtask

  task automatic test_random_cells();
    cell_t c;
    for (int n = 0; n < RANDOM_CELLS; n++) begin
      for (int k = 0; k < 9; k++) c.z[k] = rand_height();
      c.row_pos = rand_pos();
      c.col_pos = rand_pos();
      send_cell(c);
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    fail_count           = 0;
    burst_left           = 0;
    stall_left           = 0;
    stall_mode           = 0;
    stall_tick           = 0;
    rst_ni               = 1'b0;
    bez_if.ready         = 1'b0;
    cell_if.valid        = 1'b0;
    cell_if.z_up_left    = '0;
    cell_if.z_up         = '0;
    cell_if.z_up_right   = '0;
    cell_if.z_left       = '0;
    cell_if.z_center     = '0;
    cell_if.z_right      = '0;
    cell_if.z_down_left  = '0;
    cell_if.z_down       = '0;
    cell_if.z_down_right = '0;
    cell_if.row_pos      = '0;
    cell_if.col_pos      = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_extremes();
    test_position_codes();
    test_grid_sweep();
    test_random_cells();

    @(negedge clk_i);
    cell_if.valid <= 1'b0;
    while (pending_bez_q.size() != 0) @(posedge clk_i);
    // keep the clock running to catch stray beats
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** bspline_cell_to_bezier_points: PASSED **");
    end else begin
      $display("** bspline_cell_to_bezier_points: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $error("timeout, %0d Bezier beats still pending", pending_bez_q.size());
    $display("** bspline_cell_to_bezier_points: FAILED **");
    $finish;
  end

endmodule
